>>> hdl/ipv6_range_merge_macros.svh
// Assertion macros for the IPv6 range merge block.
// Used by the port checker; no other dependencies.
`ifndef IPV6_RANGE_MERGE_MACROS_SVH
`define IPV6_RANGE_MERGE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define V6RM_ASRT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("v6rm: same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define V6RM_ASRT_NEXT(lbl, clk, ante, cons, rst_n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("v6rm: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define V6RM_ASRT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("v6rm: reset check failed");

`endif

>>> hdl/v6rm_pkg.sv
// Shared types and constants for the IPv6 range merge block.
// No dependencies.
package v6rm_pkg;

    localparam int HALF_W           = 64;
    localparam int ADDR_W           = 2 * HALF_W;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // One inclusive address range.
    typedef struct packed {
        logic [ADDR_W-1:0] addr_first;
        logic [ADDR_W-1:0] addr_last;
    } t_range;

    // Work handed from the merge front to the output back end.
    typedef struct packed {
        logic   has_gap;    // closed run, sent first
        t_range gap;
        logic   has_flush;  // end of set, sent with the final flag
        t_range flush;
    } t_cmd;

endpackage

>>> hdl/v6rm_if.sv
// Valid/ready channel interfaces for input ranges and merged ranges.
// Depends on v6rm_pkg for the half-address width.
interface v6rm_in_if;
    logic                        valid;
    logic                        ready;
    logic [v6rm_pkg::HALF_W-1:0] start_high;
    logic [v6rm_pkg::HALF_W-1:0] start_low;
    logic [v6rm_pkg::HALF_W-1:0] end_high;
    logic [v6rm_pkg::HALF_W-1:0] end_low;
    logic                        last_in_set;

    modport source (output valid, start_high, start_low, end_high, end_low, last_in_set,
                    input ready);
    modport sink   (input valid, start_high, start_low, end_high, end_low, last_in_set,
                    output ready);
endinterface

interface v6rm_out_if;
    logic                        valid;
    logic                        ready;
    logic [v6rm_pkg::HALF_W-1:0] merged_start_high;
    logic [v6rm_pkg::HALF_W-1:0] merged_start_low;
    logic [v6rm_pkg::HALF_W-1:0] merged_end_high;
    logic [v6rm_pkg::HALF_W-1:0] merged_end_low;
    logic                        final_range;

    modport source (output valid, merged_start_high, merged_start_low, merged_end_high,
                    merged_end_low, final_range, input ready);
    modport sink   (input valid, merged_start_high, merged_start_low, merged_end_high,
                    merged_end_low, final_range, output ready);
endinterface

>>> hdl/v6rm_front.sv
// Merge front: accepts sorted ranges, holds the open run, decides what to send.
// Depends on v6rm_pkg and v6rm_in_if.
module v6rm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    v6rm_in_if.sink          i_rng,
    input  logic             i_q_ready,
    output logic             o_push,
    output v6rm_pkg::t_cmd   o_cmd
);
    import v6rm_pkg::*;

    logic              r_pend;
    t_range            r_run;
    logic              n_pend;
    t_range            n_run;

    logic              accept;
    logic [ADDR_W-1:0] in_start;
    logic [ADDR_W-1:0] in_end;
    logic [ADDR_W-1:0] run_inc;
    logic              contained;
    logic              overlap;
    logic              adjacent;
    logic              at_max;
    logic              gap;
    t_range            in_rng;
    t_range            next_rng;

    assign accept      = i_rng.valid && i_q_ready;
    assign i_rng.ready = i_q_ready;

    assign in_start = {i_rng.start_high, i_rng.start_low};
    assign in_end   = {i_rng.end_high, i_rng.end_low};
    assign in_rng   = '{addr_first: in_start, addr_last: in_end};

    // Compare against the held run end; adjacency never wraps past all-ones
    assign contained = in_end <= r_run.addr_last;
    assign overlap   = in_start <= r_run.addr_last;
    assign at_max    = &r_run.addr_last;
    assign run_inc   = r_run.addr_last + ADDR_W'(1);
    assign adjacent  = !at_max && (in_start == run_inc);

    // Classify the word against the run
    always_comb begin
        gap      = 1'b0;
        next_rng = r_run;
        if (!r_pend) begin
            next_rng = in_rng;
        end else if (contained) begin
            next_rng = r_run;
        end else if (overlap || adjacent) begin
            next_rng.addr_last = in_end;
        end else begin
            gap      = 1'b1;
            next_rng = in_rng;
        end
    end

    // Command toward the back end
    always_comb begin
        o_cmd.has_gap   = gap;
        o_cmd.gap       = r_run;
        o_cmd.has_flush = i_rng.last_in_set;
        o_cmd.flush     = next_rng;
    end
    assign o_push = accept && (gap || i_rng.last_in_set);

    // Run state update
    always_comb begin
        n_pend = r_pend;
        n_run  = r_run;
        if (accept) begin
            n_pend = !i_rng.last_in_set;
            n_run  = next_rng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run <= n_run;
    end

endmodule

>>> hdl/v6rm_queue.sv
// Short command queue between the merge front and the output back end.
// Depends on v6rm_pkg.
module v6rm_queue #(
    parameter int DEPTH = v6rm_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  v6rm_pkg::t_cmd   i_cmd,
    output logic             o_ready,
    output logic             o_valid,
    output v6rm_pkg::t_cmd   o_cmd,
    input  logic             i_pop
);
    import v6rm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_FULL;
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/v6rm_back.sv
// Output back end: expands each command into one or two merged-range words.
// Depends on v6rm_pkg and v6rm_out_if.
module v6rm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  v6rm_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    v6rm_out_if.source       o_mrg
);
    import v6rm_pkg::*;

    logic   r_gap_done;
    logic   r_out_valid;
    t_range r_out_rng;
    logic   r_out_final;
    logic   n_gap_done;
    logic   n_out_valid;

    logic   load;
    logic   send_gap;
    t_range sel_rng;

    // Gap word goes out before the flush word of the same command
    assign load     = i_q_valid && (!r_out_valid || o_mrg.ready);
    assign send_gap = i_cmd.has_gap && !r_gap_done;
    assign sel_rng  = send_gap ? i_cmd.gap : i_cmd.flush;
    assign o_pop    = load && !(send_gap && i_cmd.has_flush);

    always_comb begin
        n_gap_done  = r_gap_done;
        n_out_valid = r_out_valid;
        if (load) begin
            n_gap_done  = send_gap && i_cmd.has_flush;
            n_out_valid = 1'b1;
        end else if (o_mrg.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_gap_done  <= n_gap_done;
            r_out_valid <= n_out_valid;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_rng   <= sel_rng;
            r_out_final <= !send_gap;
        end
    end

    assign o_mrg.valid             = r_out_valid;
    assign o_mrg.merged_start_high = r_out_rng.addr_first[ADDR_W-1:HALF_W];
    assign o_mrg.merged_start_low  = r_out_rng.addr_first[HALF_W-1:0];
    assign o_mrg.merged_end_high   = r_out_rng.addr_last[ADDR_W-1:HALF_W];
    assign o_mrg.merged_end_low    = r_out_rng.addr_last[HALF_W-1:0];
    assign o_mrg.final_range       = r_out_final;

endmodule

>>> hdl/ipv6_range_merge.sv
// IPv6 range merge: merges a sorted stream of 128-bit address ranges.
// Input channel i_rng: start/end split into 64-bit halves plus last_in_set;
//   ranges come sorted by start ascending, end descending on equal starts.
// Output channel o_mrg: merged ranges; final_range marks the flush of a set.
// A word is moved when valid and ready are both high on a rising edge.
// Throughput: one input word per cycle while the queue has room. Each word
//   yields zero, one or two output words; the output register sends one word
//   per cycle while the receiver is ready, so a word that both closes a run
//   and ends its set yields two output words. An output word passes the front
//   decision, a queue slot and the output register.
// The front holds the open run and classifies each word combinationally with
//   128-bit compares and an increment; commands sit in a QUEUE_DEPTH entry
//   queue; i_rng.ready drops only when that queue is full.
// When the receiver stalls, the output word holds and the queue fills;
//   input keeps flowing until the queue is full.
// Reset (i_rst_n low, synchronous) drops the open run, empties the queue
//   and clears the output valid.
// Depends on v6rm_pkg, v6rm_if, v6rm_front, v6rm_queue and v6rm_back.
module ipv6_range_merge #(
    parameter int QUEUE_DEPTH = v6rm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    v6rm_in_if.sink     i_rng,
    v6rm_out_if.source  o_mrg
);
    import v6rm_pkg::*;

    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    v6rm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rng     (i_rng),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    v6rm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    v6rm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_mrg     (o_mrg)
    );

endmodule

>>> hdl/v6rm_chk.sv
// Port-level checker for the IPv6 range merge block, bound to the top level.
// Depends on ipv6_range_merge_macros.svh and v6rm_pkg.
`include "ipv6_range_merge_macros.svh"

module v6rm_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [v6rm_pkg::HALF_W-1:0] i_out_sh,
    input logic [v6rm_pkg::HALF_W-1:0] i_out_sl,
    input logic [v6rm_pkg::HALF_W-1:0] i_out_eh,
    input logic [v6rm_pkg::HALF_W-1:0] i_out_el,
    input logic                        i_out_final
);
    import v6rm_pkg::*;

    logic                  out_stall;
    logic                  last_taken;
    logic [4*HALF_W:0]     out_word;

    // Handshake shorthands and the full output word
    assign out_stall  = i_out_valid && !i_out_ready;
    assign last_taken = i_in_valid && i_in_ready && i_in_last;
    assign out_word   = {i_out_sh, i_out_sl, i_out_eh, i_out_el, i_out_final};

    // Reset empties the output register
    `V6RM_ASRT_RESET(a_rst_out, i_clk, !i_rst_n, !i_out_valid)

    // A stalled output word holds
    `V6RM_ASRT_NEXT(a_stall_hold, i_clk, out_stall, i_out_valid && $stable(out_word), i_rst_n)

    // Backpressure on input implies queued work reaches an empty output next
    `V6RM_ASRT_NEXT(a_full_drains, i_clk, !i_in_ready && !i_out_valid, i_out_valid, i_rst_n)

    // End of a set always shows an output word after the queue slot and the output register
    `V6RM_ASRT_IMPL(a_last_out, i_clk, i_rst_n, last_taken, ##2 i_out_valid)

endmodule

bind ipv6_range_merge v6rm_chk u_v6rm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rng.valid),
    .i_in_ready  (i_rng.ready),
    .i_in_last   (i_rng.last_in_set),
    .i_out_valid (o_mrg.valid),
    .i_out_ready (o_mrg.ready),
    .i_out_sh    (o_mrg.merged_start_high),
    .i_out_sl    (o_mrg.merged_start_low),
    .i_out_eh    (o_mrg.merged_end_high),
    .i_out_el    (o_mrg.merged_end_low),
    .i_out_final (o_mrg.final_range)
);
